// ===== rtl/jbmp_pkg.sv =====
// Package: result and error codes, field widths and the zigzag table for the marker parser.
package jbmp_pkg;

  localparam int unsigned MaxScansDefault      = 3;
  localparam int unsigned MaxHuffValuesDefault = 256;
  localparam int unsigned QuantEntries         = 64;

  localparam logic [7:0] MarkerPrefix = 8'hFF;

  typedef enum logic [3:0] {
    KIND_SCAN_BYTE = 4'd0,
    KIND_SEG_START = 4'd1,
    KIND_QUANT     = 4'd2,
    KIND_HCOUNT    = 4'd3,
    KIND_HVALUE    = 4'd4,
    KIND_FRAME     = 4'd5,
    KIND_RESTART   = 4'd6,
    KIND_SCAN_START = 4'd7,
    KIND_DONE      = 4'd8,
    KIND_ERROR     = 4'd9
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NO_SOI      = 4'd0,
    ERR_APP0        = 4'd1,
    ERR_DQT         = 4'd2,
    ERR_SOF         = 4'd3,
    ERR_DHT         = 4'd4,
    ERR_DRI         = 4'd5,
    ERR_SOS         = 4'd6,
    ERR_UNSUPPORTED = 4'd7,
    ERR_BAD_MARKER  = 4'd8,
    ERR_TRUNCATED   = 4'd9,
    ERR_HUFF_OVFL   = 4'd10
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  result_kind;
    logic [1:0]  table_id;
    logic [7:0]  entry_index;
    logic [15:0] value_word;
    logic [15:0] frame_height;
    logic [7:0]  component_total;
    logic [15:0] segment_number;
    logic [1:0]  scan_number;
    logic [3:0]  error_code;
  } out_item_t;

  function automatic logic [5:0] zz_natural(input logic [5:0] k);
    logic [5:0] t [64];
    t = '{6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
          6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
          6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
          6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
          6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
          6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
          6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
          6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63};
    return t[k];
  endfunction

  function automatic logic [7:0] app0_expect(input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0:    r = 8'h4A;
      3'd1:    r = 8'h46;
      3'd2:    r = 8'h49;
      3'd3:    r = 8'h46;
      3'd4:    r = 8'h00;
      default: r = 8'h01;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/jbmp_stream_if.sv =====
// Interface: valid/ready stream channel carrying one payload word.
interface jbmp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/jbmp_out_reg.sv =====
// Output register stage with a skid slot for the result channel.
module jbmp_out_reg import jbmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      space_o,
  jbmp_stream_if.source out_o
);
  logic      main_vld_q, skid_vld_q;
  out_item_t main_q, skid_q;

  assign space_o     = !skid_vld_q;
  assign out_o.valid = main_vld_q;
  assign out_o.payload = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!main_vld_q || out_o.ready) begin
        // advance: skid first, then the new request
        if (skid_vld_q) begin
          main_vld_q <= 1'b1;
          main_q     <= skid_q;
          skid_vld_q <= push_i;
          skid_q     <= item_i;
        end else begin
          main_vld_q <= push_i;
          main_q     <= item_i;
        end
      end else if (push_i) begin
        skid_vld_q <= 1'b1;
        skid_q     <= item_i;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_vld_q) else $error("result pushed into full skid");
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q) else $error("skid holds without main");
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_o.ready) |=> skid_vld_q && $stable(skid_q))
    else $error("skid lost");
`endif
endmodule

// ===== rtl/jpeg_baseline_marker_parser.sv =====
// Top level: JPEG baseline marker segment parser, one byte per cycle while ready.
//
//  channel  dir  payload                         handshake
//  in_s     in   data_byte, end_of_file          valid/ready
//  res_m    out  kind, table, index, value, ...  valid/ready
//
// Each byte is parsed in the cycle it is accepted; its result (if any) is
// registered in the output stage. One byte per cycle while ready is high.
// Ready drops only when the output stage and its skid slot are both full.
// Reset is asynchronous; the parser waits for SOI after reset.
module jpeg_baseline_marker_parser import jbmp_pkg::*; #(
  parameter int unsigned MaxScans      = MaxScansDefault,
  parameter int unsigned MaxHuffValues = MaxHuffValuesDefault
) (
  input logic clk_i,
  input logic rst_ni,
  jbmp_stream_if.sink   in_s,
  jbmp_stream_if.source res_m
);
  typedef enum logic [4:0] {
    PH_SOI0, PH_SOI1, PH_MARK0, PH_MARK1, PH_DONE, PH_ERROR, PH_SCAN,
    PH_LEN_HI, PH_LEN_LO, PH_SKIP, PH_APP0, PH_DQT_ID, PH_DQT_ENT,
    PH_SOF_HDR, PH_SOF_COMP, PH_DHT_ID, PH_DHT_CNT, PH_DHT_VAL,
    PH_DRI_HI, PH_DRI_LO, PH_SOS_HDR
  } phase_e;

  typedef enum logic [2:0] {
    SEG_SKIP, SEG_APP0, SEG_DQT, SEG_SOF, SEG_DHT, SEG_DRI, SEG_SOS
  } seg_e;

  phase_e      ph_q, ph_d;
  seg_e        seg_q, seg_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  fp_q, fp_d;
  logic [1:0]  tab_q, tab_d;
  logic [11:0] hv_q, hv_d;
  logic [7:0]  held_q, held_d;
  logic        hvld_q, hvld_d;
  logic [1:0]  scans_q, scans_d;
  logic [15:0] segs_q, segs_d;
  logic        rdef_q, rdef_d;
  logic [15:0] hdr_q, hdr_d;
  logic [15:0] fw_q, fw_d;
  logic [7:0]  comp_q, comp_d;

  logic      space, take, emit;
  out_item_t res;
  logic [7:0] b;
  logic [15:0] len;
  logic [16:0] need;
  logic [11:0] hv_sum;
  logic [7:0] fp1;

  assign in_s.ready = space;
  assign take = in_s.valid && space;
  assign b    = in_s.payload.data_byte;
  assign len  = {rem_q[15:8], b};
  assign need = 17'd8 + 17'd3 * {9'd0, b};
  assign hv_sum = hv_q + {4'd0, b};
  assign fp1  = fp_q + 8'd1;

  always_comb begin
    ph_d = ph_q; seg_d = seg_q; rem_d = rem_q; fp_d = fp_q; tab_d = tab_q;
    hv_d = hv_q; held_d = held_q; hvld_d = hvld_q; scans_d = scans_q;
    segs_d = segs_q; rdef_d = rdef_q; hdr_d = hdr_q; fw_d = fw_q; comp_d = comp_q;
    emit = 1'b0;
    res  = '0;
    unique case (ph_q)
      PH_DONE, PH_ERROR: ;
      PH_SOI0: if (b != MarkerPrefix) begin
          emit = 1'b1; res.result_kind = KIND_ERROR; res.error_code = ERR_NO_SOI;
          ph_d = PH_ERROR;
        end else ph_d = PH_SOI1;
      PH_SOI1: if (b != 8'hD8) begin
          emit = 1'b1; res.result_kind = KIND_ERROR; res.error_code = ERR_NO_SOI;
          ph_d = PH_ERROR;
        end else ph_d = PH_MARK0;
      PH_MARK0: if (b != MarkerPrefix) begin
          emit = 1'b1; res.result_kind = KIND_ERROR; res.error_code = ERR_BAD_MARKER;
          ph_d = PH_ERROR;
        end else ph_d = PH_MARK1;
      PH_MARK1: begin
        ph_d = PH_LEN_HI;
        if (b == 8'hD9) begin
          emit = 1'b1; res.result_kind = KIND_DONE; ph_d = PH_DONE;
        end else if (b == 8'hE0) seg_d = SEG_APP0;
        else if ((b >= 8'hE1 && b <= 8'hEF) || b == 8'hFE || b == 8'hCC || b == 8'hDC)
          seg_d = SEG_SKIP;
        else if (b == 8'hDB) seg_d = SEG_DQT;
        else if (b == 8'hC0 || b == 8'hC1) seg_d = SEG_SOF;
        else if (b == 8'hC4) seg_d = SEG_DHT;
        else if (b == 8'hDD) seg_d = SEG_DRI;
        else if (b == 8'hDA) seg_d = SEG_SOS;
        else begin
          emit = 1'b1; res.result_kind = KIND_ERROR; ph_d = PH_ERROR;
          res.error_code = (b >= 8'hC2 && b <= 8'hCF) ? ERR_UNSUPPORTED : ERR_BAD_MARKER;
        end
      end
      PH_LEN_HI: begin
        rem_d = {b, 8'd0}; ph_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        fp_d = '0;
        res.result_kind = KIND_ERROR;
        case (seg_q)
          SEG_SKIP: if (len < 16'd2) begin
              emit = 1'b1; res.error_code = ERR_BAD_MARKER; ph_d = PH_ERROR;
            end else begin
              rem_d = len - 16'd2;
              ph_d = (len == 16'd2) ? PH_MARK0 : PH_SKIP;
            end
          SEG_APP0: if (len != 16'd16) begin
              emit = 1'b1; res.error_code = ERR_APP0; ph_d = PH_ERROR;
            end else ph_d = PH_APP0;
          SEG_DQT: if (len != 16'(QuantEntries + 3)) begin
              emit = 1'b1; res.error_code = ERR_DQT; ph_d = PH_ERROR;
            end else ph_d = PH_DQT_ID;
          SEG_SOF: if (len < 16'd6) begin
              emit = 1'b1; res.error_code = ERR_SOF; ph_d = PH_ERROR;
            end else begin
              rem_d = len; ph_d = PH_SOF_HDR;
            end
          SEG_DHT: begin
            rem_d = (len >= 16'd2) ? len - 16'd2 : '0; ph_d = PH_DHT_ID;
          end
          SEG_DRI: if (len != 16'd4 || rdef_q) begin
              emit = 1'b1; res.error_code = ERR_DRI; ph_d = PH_ERROR;
            end else ph_d = PH_DRI_HI;
          default: if (len != 16'd8) begin
              emit = 1'b1; res.error_code = ERR_SOS; ph_d = PH_ERROR;
            end else ph_d = PH_SOS_HDR;
        endcase
      end
      PH_SKIP: begin
        rem_d = rem_q - 16'd1;
        if (rem_q == 16'd1) ph_d = PH_MARK0;
      end
      PH_APP0: begin
        if (fp_q < 8'd7 && b != app0_expect(fp_q[2:0])) begin
          emit = 1'b1; res.result_kind = KIND_ERROR; res.error_code = ERR_APP0;
          ph_d = PH_ERROR;
        end else if (fp_q >= 8'd13) ph_d = PH_MARK0;
        else fp_d = fp1;
      end
      PH_DQT_ID: if (b > 8'd1) begin
          emit = 1'b1; res.result_kind = KIND_ERROR; res.error_code = ERR_DQT;
          ph_d = PH_ERROR;
        end else begin
          tab_d = b[1:0]; fp_d = '0; ph_d = PH_DQT_ENT;
        end
      PH_DQT_ENT: begin
        emit = 1'b1; res.result_kind = KIND_QUANT; res.table_id = tab_q;
        res.entry_index = {2'd0, zz_natural(fp_q[5:0])};
        res.value_word = {8'd0, b};
        fp_d = fp1;
        if (fp1 >= 8'(QuantEntries)) ph_d = PH_MARK0;
      end
      PH_SOF_HDR: begin
        if (fp_q == 8'd0 && b != 8'd8) begin
          emit = 1'b1; res.result_kind = KIND_ERROR; res.error_code = ERR_SOF;
          ph_d = PH_ERROR;
        end else if (fp_q < 8'd5) begin
          if (fp_q == 8'd1) hdr_d = {b, 8'd0};
          if (fp_q == 8'd2) hdr_d = {hdr_q[15:8], b};
          if (fp_q == 8'd3) fw_d = {b, 8'd0};
          if (fp_q == 8'd4) fw_d = {fw_q[15:8], b};
          fp_d = fp1;
        end else begin
          comp_d = b;
          if ({1'b0, rem_q} < need) begin
            emit = 1'b1; res.result_kind = KIND_ERROR; res.error_code = ERR_SOF;
            ph_d = PH_ERROR;
          end else begin
            rem_d = rem_q - need[15:0];
            if (b == 8'd0) begin
              emit = 1'b1; res.result_kind = KIND_FRAME; res.value_word = fw_q;
              res.frame_height = hdr_q; res.component_total = 8'd0;
              ph_d = (rem_q != need[15:0]) ? PH_SKIP : PH_MARK0;
            end else begin
              fp_d = '0; tab_d = '0; ph_d = PH_SOF_COMP;
            end
          end
        end
      end
      PH_SOF_COMP: begin
        if ((tab_q == 2'd0 && b != fp1) || (tab_q == 2'd1 && b != 8'h11) ||
            (tab_q >= 2'd2 && fp_q == 8'd0 && b != 8'd0) ||
            (tab_q >= 2'd2 && (fp_q == 8'd1 || fp_q == 8'd2) && b != 8'd1)) begin
          emit = 1'b1; res.result_kind = KIND_ERROR; res.error_code = ERR_SOF;
          ph_d = PH_ERROR;
        end else if (tab_q >= 2'd2) begin
          tab_d = '0; fp_d = fp1;
          if (fp1 >= comp_q) begin
            emit = 1'b1; res.result_kind = KIND_FRAME; res.value_word = fw_q;
            res.frame_height = hdr_q; res.component_total = comp_q;
            ph_d = (rem_q != 16'd0) ? PH_SKIP : PH_MARK0;
          end
        end else tab_d = tab_q + 2'd1;
      end
      PH_DHT_ID: begin
        case (b)
          8'd0:  tab_d = 2'd0;
          8'd16: tab_d = 2'd1;
          8'd1:  tab_d = 2'd2;
          8'd17: tab_d = 2'd3;
          default: begin
            emit = 1'b1; res.result_kind = KIND_ERROR; res.error_code = ERR_DHT;
          end
        endcase
        if (emit) ph_d = PH_ERROR;
        else begin
          if (rem_q != 16'd0) rem_d = rem_q - 16'd1;
          hv_d = '0; fp_d = '0; ph_d = PH_DHT_CNT;
        end
      end
      PH_DHT_CNT: begin
        emit = 1'b1;
        if (rem_q == 16'd0) begin
          res.result_kind = KIND_ERROR; res.error_code = ERR_DHT; ph_d = PH_ERROR;
        end else begin
          rem_d = rem_q - 16'd1; hv_d = hv_sum; fp_d = fp1;
          res.result_kind = KIND_HCOUNT; res.table_id = tab_q;
          res.entry_index = fp1; res.value_word = {8'd0, b};
          if (fp1 >= 8'd16) begin
            if (hv_sum > 12'(MaxHuffValues)) begin
              res = '0; res.result_kind = KIND_ERROR; res.error_code = ERR_HUFF_OVFL;
              ph_d = PH_ERROR;
            end else begin
              fp_d = '0;
              if (hv_sum == 12'd0) ph_d = (rem_q != 16'd1) ? PH_DHT_ID : PH_MARK0;
              else ph_d = PH_DHT_VAL;
            end
          end
        end
      end
      PH_DHT_VAL: begin
        emit = 1'b1;
        if (rem_q == 16'd0) begin
          res.result_kind = KIND_ERROR; res.error_code = ERR_DHT; ph_d = PH_ERROR;
        end else begin
          rem_d = rem_q - 16'd1;
          res.result_kind = KIND_HVALUE; res.table_id = tab_q;
          res.entry_index = fp_q; res.value_word = {8'd0, b};
          fp_d = fp1; hv_d = hv_q - 12'd1;
          if (hv_q == 12'd1) ph_d = (rem_q != 16'd1) ? PH_DHT_ID : PH_MARK0;
        end
      end
      PH_DRI_HI: begin
        hdr_d = {b, 8'd0}; ph_d = PH_DRI_LO;
      end
      PH_DRI_LO: begin
        hdr_d = {hdr_q[15:8], b};
        rdef_d = ({hdr_q[15:8], b} != 16'd0);
        emit = 1'b1; res.result_kind = KIND_RESTART; res.value_word = {hdr_q[15:8], b};
        ph_d = PH_MARK0;
      end
      PH_SOS_HDR: begin
        res.result_kind = KIND_ERROR; res.error_code = ERR_SOS;
        if (fp_q == 8'd0 && b != 8'd1) begin
          emit = 1'b1; ph_d = PH_ERROR;
        end else if (fp_q == 8'd2 && ((hdr_q == 16'd1 && b != 8'd0) ||
                     ((hdr_q == 16'd2 || hdr_q == 16'd3) && b != 8'h11))) begin
          emit = 1'b1; ph_d = PH_ERROR;
        end else if (fp_q < 8'd5) begin
          if (fp_q == 8'd1) hdr_d = {8'd0, b};
          fp_d = fp1;
        end else if ({30'd0, scans_q} >= MaxScans) begin
          emit = 1'b1; ph_d = PH_ERROR;
        end else begin
          emit = 1'b1; res = '0; res.result_kind = KIND_SCAN_START;
          res.segment_number = segs_q; res.scan_number = scans_q;
          segs_d = segs_q + 16'd1; scans_d = scans_q + 2'd1;
          hvld_d = 1'b0; ph_d = PH_SCAN;
        end
      end
      PH_SCAN: begin
        res.scan_number = scans_q - 2'd1;
        if (hvld_q && held_q == MarkerPrefix && b >= 8'hD0 && b <= 8'hD7) begin
          emit = 1'b1; res.result_kind = KIND_SEG_START; res.segment_number = segs_q;
          segs_d = segs_q + 16'd1; hvld_d = 1'b0;
        end else if (hvld_q && held_q == MarkerPrefix && b == 8'hD9) begin
          emit = 1'b1; res.result_kind = KIND_DONE; res.scan_number = '0;
          hvld_d = 1'b0; ph_d = PH_DONE;
        end else if (hvld_q && held_q == MarkerPrefix && b == 8'hDA) begin
          hvld_d = 1'b0; seg_d = SEG_SOS; ph_d = PH_LEN_HI;
        end else begin
          emit = hvld_q; res.result_kind = KIND_SCAN_BYTE;
          res.value_word = {8'd0, held_q}; res.segment_number = segs_q - 16'd1;
          held_d = b; hvld_d = 1'b1;
        end
      end
      default: ;
    endcase
    // truncation overrides whatever the byte produced unless it ended the parse
    if (in_s.payload.end_of_file && ph_q != PH_DONE && ph_q != PH_ERROR &&
        ph_d != PH_DONE && ph_d != PH_ERROR) begin
      emit = 1'b1; res = '0; res.result_kind = KIND_ERROR;
      res.error_code = ERR_TRUNCATED; ph_d = PH_ERROR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_SOI0; seg_q <= SEG_SKIP; rem_q <= '0; fp_q <= '0; tab_q <= '0;
      hv_q <= '0; held_q <= '0; hvld_q <= 1'b0; scans_q <= '0; segs_q <= '0;
      rdef_q <= 1'b0; hdr_q <= '0; fw_q <= '0; comp_q <= '0;
    end else if (take) begin
      ph_q <= ph_d; seg_q <= seg_d; rem_q <= rem_d; fp_q <= fp_d; tab_q <= tab_d;
      hv_q <= hv_d; held_q <= held_d; hvld_q <= hvld_d; scans_q <= scans_d;
      segs_q <= segs_d; rdef_q <= rdef_d; hdr_q <= hdr_d; fw_q <= fw_d;
      comp_q <= comp_d;
    end
  end

  jbmp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take && emit),
    .item_i  (res),
    .space_o (space),
    .out_o   (res_m)
  );

`ifndef ASSERT_OFF
  a_terminal_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_DONE || ph_q == PH_ERROR) |=> $stable(ph_q)) else $error("left end state");
  a_no_emit_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_DONE || ph_q == PH_ERROR) |-> !emit) else $error("result after end");
  a_scans_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {30'd0, scans_q} <= MaxScans) else $error("too many scans");
  a_huff_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_DHT_VAL |-> hv_q != 12'd0 && hv_q <= 12'(MaxHuffValues))
    else $error("huffman count out of range");
`endif
endmodule
